// ===== rtl/erd_pkg.sv =====
// Shared constants, register codes and stage structures for the encoder runaway detector.
// Used by erd_rate, erd_accum and the top module; depends on nothing else.
package erd_pkg;

    localparam int NUM_MOTORS = 2;
    localparam int MOTOR_W    = 1;
    localparam int ADDR_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    localparam int COUNT_W    = 32;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 48;

    localparam logic [PROD_W-1:0] MS_PER_SECOND = 48'd1000;
    localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 16'd1900;
    localparam logic [CFG_W-1:0]  LIMIT_RESET     = 16'd156;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT  = 2'd1;

    typedef struct packed {
        logic [COUNT_W-1:0] diff;
        logic [PROD_W-1:0]  lhs;
        logic [PROD_W-1:0]  rhs;
    } rate_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  motor;
        logic               in_range;
        logic               primed;
        logic [COUNT_W-1:0] diff;
        logic [PROD_W-1:0]  lhs;
        logic [PROD_W-1:0]  rhs;
        logic [TOTAL_W-1:0] total;
    } s2_t;

    typedef struct packed {
        logic               overspeed;
        logic               fault;
        logic               write;
        logic [TOTAL_W-1:0] total;
    } acc_t;

endpackage

// ===== rtl/erd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written in the same cycle returns the old data. No dependencies.
module erd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/erd_rate.sv =====
// First compute stage: absolute count difference, elapsed time and both sides of the rate test.
// Depends on erd_pkg.
module erd_rate (
    input  logic [erd_pkg::COUNT_W-1:0] count,
    input  logic [erd_pkg::TIME_W-1:0]  time_ms,
    input  logic [erd_pkg::COUNT_W-1:0] last_count,
    input  logic [erd_pkg::TIME_W-1:0]  last_time,
    input  logic [erd_pkg::CFG_W-1:0]   threshold,
    output erd_pkg::rate_t              rate
);

    logic [erd_pkg::COUNT_W-1:0] d_fwd;
    logic [erd_pkg::COUNT_W-1:0] d_rev;
    logic [erd_pkg::COUNT_W-1:0] diff;
    logic [erd_pkg::TIME_W-1:0]  dt;

    assign d_fwd = count - last_count;
    assign d_rev = last_count - count;
    assign diff  = d_fwd[erd_pkg::COUNT_W-1] ? d_rev : d_fwd;
    assign dt    = time_ms - last_time;

    always_comb
    begin
        rate.diff = diff;
        rate.lhs  = erd_pkg::PROD_W'(diff) * erd_pkg::MS_PER_SECOND;
        rate.rhs  = erd_pkg::PROD_W'(threshold) * erd_pkg::PROD_W'(dt);
    end

endmodule

// ===== rtl/erd_accum.sv =====
// Second compute stage: overspeed decision, saturating accumulation and the runaway check.
// Depends on erd_pkg.
module erd_accum (
    input  erd_pkg::s2_t              stage,
    input  logic [erd_pkg::CFG_W-1:0] limit,
    output erd_pkg::acc_t             acc
);

    logic [erd_pkg::TOTAL_W:0]   sum;
    logic [erd_pkg::TOTAL_W-1:0] sat;
    logic                        over;
    logic                        fault;

    assign over  = stage.in_range && stage.primed && (stage.lhs > stage.rhs);
    assign sum   = {1'b0, stage.total} + {1'b0, stage.diff};
    assign sat   = sum[erd_pkg::TOTAL_W] ? '1 : sum[erd_pkg::TOTAL_W-1:0];
    assign fault = over && (sat > erd_pkg::TOTAL_W'(limit));

    always_comb
    begin
        acc.overspeed = over;
        acc.fault     = fault;
        acc.write     = stage.in_range;
        acc.total     = (over && !fault) ? sat : '0;
    end

endmodule

// ===== rtl/encoder_runaway_detector.sv =====
// Encoder runaway detector: one encoder sample per request in, one result per request out.
// An accepted sample's result is offered once it has passed the input, second-stage and
// output registers, and a new sample can be taken in every cycle unless m_axis_tready holds
// the output; the rate is set by the accumulator read-modify-write loop, which forwards the
// value being written so that back-to-back samples of one motor see each other. The last
// count and time of each motor live in one RAM that is read and written on the accept cycle;
// the overspeed accumulator lives in a second RAM, read on accept and written back from the
// second compute stage. Primed flags sit in flip-flops and are cleared by reset, so no clearing
// pass is needed after reset. Depends on erd_pkg, erd_ram, erd_rate and erd_accum.
module encoder_runaway_detector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // encoder_count[31:0], time_ms[63:32]
    input  logic [erd_pkg::MOTOR_W-1:0]    s_axis_tuser,  // motor
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // overspeed, runaway flag,
                                                          // accumulated_distance[33:2], zeros
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [erd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = erd_pkg::ADDR_W;
    localparam int CTW = erd_pkg::COUNT_W + erd_pkg::TIME_W;

    logic [erd_pkg::CFG_W-1:0]   thr_reg;
    logic [erd_pkg::CFG_W-1:0]   lim_reg;
    logic [erd_pkg::NUM_MOTORS-1:0] primed_reg;

    logic                        v1_reg;
    logic [AW-1:0]               s1_motor_reg;
    logic                        s1_in_range_reg;
    logic                        s1_primed_reg;
    logic [erd_pkg::COUNT_W-1:0] s1_count_reg;
    logic [erd_pkg::TIME_W-1:0]  s1_time_reg;
    logic                        fix_valid_reg;
    logic [erd_pkg::TOTAL_W-1:0] fix_data_reg;

    logic                        v2_reg;
    erd_pkg::s2_t                s2_reg;
    erd_pkg::s2_t                s2_next;

    logic                        ov_reg;
    logic                        out_over_reg;
    logic                        out_fault_reg;
    logic [erd_pkg::TOTAL_W-1:0] out_acc_reg;

    logic                        adv_o;
    logic                        adv2;
    logic                        adv1;
    logic                        in_accept;
    logic [AW-1:0]               in_addr;
    logic                        in_range;
    logic [erd_pkg::COUNT_W-1:0] in_count;
    logic [erd_pkg::TIME_W-1:0]  in_time;

    logic [CTW-1:0]              ct_rdata;
    logic [erd_pkg::TOTAL_W-1:0] tot_rdata;
    logic                        we_tot;

    erd_pkg::rate_t              rate;
    erd_pkg::acc_t               acc;

    logic                        fix_valid_next;
    logic [erd_pkg::TOTAL_W-1:0] total_next;

    assign adv_o         = !ov_reg || m_axis_tready;
    assign adv2          = !v2_reg || adv_o;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1;
    assign in_accept     = s_axis_tvalid && adv1;
    assign cfg_ready     = 1'b1;

    assign in_addr  = AW'(s_axis_tuser);
    assign in_range = 32'(s_axis_tuser) < 32'(erd_pkg::NUM_MOTORS);
    assign in_count = s_axis_tdata[31:0];
    assign in_time  = s_axis_tdata[63:32];

    assign we_tot = v2_reg && adv_o && acc.write;

    erd_ram #(
        .WIDTH (CTW),
        .DEPTH (erd_pkg::NUM_MOTORS)
    ) u_ct_ram (
        .clk   (clk),
        .we    (in_accept && in_range),
        .waddr (in_addr),
        .wdata ({in_time, in_count}),
        .re    (adv1),
        .raddr (in_addr),
        .rdata (ct_rdata)
    );

    erd_ram #(
        .WIDTH (erd_pkg::TOTAL_W),
        .DEPTH (erd_pkg::NUM_MOTORS)
    ) u_tot_ram (
        .clk   (clk),
        .we    (we_tot),
        .waddr (s2_reg.motor),
        .wdata (acc.total),
        .re    (adv1),
        .raddr (in_addr),
        .rdata (tot_rdata)
    );

    erd_rate u_rate (
        .count      (s1_count_reg),
        .time_ms    (s1_time_reg),
        .last_count (ct_rdata[erd_pkg::COUNT_W-1:0]),
        .last_time  (ct_rdata[CTW-1:erd_pkg::COUNT_W]),
        .threshold  (thr_reg),
        .rate       (rate)
    );

    erd_accum u_accum (
        .stage (s2_reg),
        .limit (lim_reg),
        .acc   (acc)
    );

    // The accumulator read on accept misses a write-back made in the same cycle.
    assign fix_valid_next = we_tot && (s2_reg.motor == in_addr);

    always_comb
    begin
        if (we_tot && (s2_reg.motor == s1_motor_reg))
        begin
            total_next = acc.total;
        end
        else if (fix_valid_reg)
        begin
            total_next = fix_data_reg;
        end
        else
        begin
            total_next = tot_rdata;
        end
    end

    always_comb
    begin
        s2_next.motor    = s1_motor_reg;
        s2_next.in_range = s1_in_range_reg;
        s2_next.primed   = s1_primed_reg;
        s2_next.diff     = rate.diff;
        s2_next.lhs      = rate.lhs;
        s2_next.rhs      = rate.rhs;
        s2_next.total    = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= erd_pkg::THRESHOLD_RESET;
            lim_reg <= erd_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                erd_pkg::REG_SPEED_THRESHOLD: thr_reg <= cfg_data;
                erd_pkg::REG_DISTANCE_LIMIT:  lim_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            ov_reg        <= 1'b0;
            fix_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept && in_range)
            begin
                primed_reg[in_addr] <= 1'b1;
            end
            if (adv1)
            begin
                v1_reg        <= s_axis_tvalid;
                fix_valid_reg <= fix_valid_next;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv_o)
            begin
                ov_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_motor_reg    <= in_addr;
            s1_in_range_reg <= in_range;
            s1_primed_reg   <= in_range && primed_reg[in_addr];
            s1_count_reg    <= in_count;
            s1_time_reg     <= in_time;
            fix_data_reg    <= acc.total;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv_o)
        begin
            out_over_reg  <= acc.overspeed;
            out_fault_reg <= acc.fault;
            out_acc_reg   <= acc.total;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'b0, out_acc_reg, out_fault_reg, out_over_reg};

endmodule
